// ===== design/rectangle_raster_canvas_assert.svh =====
// Assertion macros for the rectangle raster canvas.
`ifndef RECTANGLE_RASTER_CANVAS_ASSERT_SVH
`define RECTANGLE_RASTER_CANVAS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrc_pkg.sv =====
// Shared types and constants for the rectangle raster canvas.
package rrc_pkg;

  localparam int DATA_W = 24;
  localparam int SIZE_W = 11;
  localparam int BND_W  = 26;
  localparam int CHAR_W = 8;
  localparam int CFG_W  = 9;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BG     = 2'd2;

  localparam logic [CHAR_W-1:0] RESET_CHAR = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_REJECT = 2'd1,
    STS_RANGE  = 2'd2
  } sts_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [BND_W-1:0] xlo;
    logic signed [BND_W-1:0] xhi;
    logic signed [BND_W-1:0] ylo;
    logic signed [BND_W-1:0] yhi;
  } bnd_t;

endpackage

// ===== design/rrc_canvas_mem.sv =====
// Canvas byte store: one write port, one registered read port.
module rrc_canvas_mem import rrc_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem_r [DEPTH];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/rrc_bound_unit.sv =====
// Shared adder/shifter that turns the fixed-point box into integer pixel bounds.
module rrc_bound_unit import rrc_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] rect_left,
  input  logic signed [DATA_W-1:0] rect_top,
  input  logic signed [DATA_W-1:0] rect_width,
  input  logic signed [DATA_W-1:0] rect_height,
  output bnd_t                     bnd,
  output logic                     done
);

  localparam logic signed [BND_W-1:0] ONE_M1 = BND_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [DATA_W-1:0] left_r, top_r, wid_r, hgt_r;
  logic signed [DATA_W-1:0] left_nxt, top_nxt, wid_nxt, hgt_nxt;
  logic                     busy_r, busy_nxt;
  logic [1:0]               step_r, step_nxt;
  bnd_t                     bnd_r, bnd_nxt;
  logic signed [BND_W-1:0]  op_a, op_b, sum, quo;

  // step 0: ceil(left), 1: floor(left+width), 2: ceil(top), 3: floor(top+height)
  always_comb begin
    op_a = step_r[1] ? BND_W'(top_r) : BND_W'(left_r);
    if (step_r[0]) begin
      op_b = step_r[1] ? BND_W'(hgt_r) : BND_W'(wid_r);
    end else begin
      op_b = ONE_M1;
    end
    sum = op_a + op_b;
    quo = sum >>> FRAC_BITS;
  end

  always_comb begin
    left_nxt = left_r;
    top_nxt  = top_r;
    wid_nxt  = wid_r;
    hgt_nxt  = hgt_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    bnd_nxt  = bnd_r;
    if (start) begin
      left_nxt = rect_left;
      top_nxt  = rect_top;
      wid_nxt  = rect_width;
      hgt_nxt  = rect_height;
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      case (step_r)
        2'd0:    bnd_nxt.xlo = quo;
        2'd1:    bnd_nxt.xhi = quo;
        2'd2:    bnd_nxt.ylo = quo;
        default: bnd_nxt.yhi = quo;
      endcase
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    top_r  <= top_nxt;
    wid_r  <= wid_nxt;
    hgt_r  <= hgt_nxt;
    bnd_r  <= bnd_nxt;
  end

  assign bnd  = bnd_r;
  assign done = busy_r && (step_r == 2'd3);

endmodule

// ===== design/rectangle_raster_canvas.sv =====
// Rectangle raster canvas top level: sequencer, pixel walk and stream ports.
`include "rectangle_raster_canvas_assert.svh"

// A byte canvas of up to MAX_WIDTH x MAX_HEIGHT pixels. Clear and draw commands
// walk every used pixel through the single memory write port, one pixel per
// cycle, a draw after its bounds come from the shared bound adder. A rejected
// draw, a read outside the canvas and command 3 go straight to the result, a
// read after its registered memory read; each result then waits in the output
// register. One item is in work at a time; in_tready is high only while
// idle. After reset a clearing pass fills the whole store with spaces before
// the first input transfer (configuration writes are taken during it).
module rectangle_raster_canvas import rrc_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [0] filled, [24:1] rect_left, [48:25] rect_top, [72:49] rect_width,
  // [96:73] rect_height, [104:97] paint_char, [112:105] pixel_col,
  // [120:113] pixel_row, rest zero
  input  logic [127:0]      in_tdata,
  // [1:0] command
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [1:0] status, [9:2] pixel_value, rest zero
  output logic [15:0]       out_tdata,
  // row_end
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SIZE_W-1:0] MAXW_S = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAXH_S = SIZE_W'(MAX_HEIGHT);
  localparam logic [AW-1:0]     ROW_STEP = AW'(MAX_WIDTH);

  // input fields
  cmd_t                     in_cmd;
  logic                     in_filled;
  logic signed [DATA_W-1:0] in_left, in_top, in_wid, in_hgt;
  logic [CHAR_W-1:0]        in_paint;
  logic [7:0]               in_col, in_row;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_filled = in_tdata[0];
  assign in_left   = $signed(in_tdata[24:1]);
  assign in_top    = $signed(in_tdata[48:25]);
  assign in_wid    = $signed(in_tdata[72:49]);
  assign in_hgt    = $signed(in_tdata[96:73]);
  assign in_paint  = in_tdata[104:97];
  assign in_col    = in_tdata[112:105];
  assign in_row    = in_tdata[120:113];

  // configuration registers
  logic [CFG_W-1:0]  cw_r, ch_r;
  logic [CHAR_W-1:0] bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= 9'd256;
      ch_r <= 9'd256;
      bg_r <= RESET_CHAR;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_WIDTH) begin
        cw_r <= cfg_wdata;
      end
      if (cfg_addr == CFG_HEIGHT) begin
        ch_r <= cfg_wdata;
      end
      if (cfg_addr == CFG_BG) begin
        bg_r <= cfg_wdata[CHAR_W-1:0];
      end
    end
  end

  logic [SIZE_W-1:0] used_w, used_h;

  always_comb begin
    if (cw_r == '0) begin
      used_w = SIZE_W'(1);
    end else if (SIZE_W'(cw_r) > MAXW_S) begin
      used_w = MAXW_S;
    end else begin
      used_w = SIZE_W'(cw_r);
    end
    if (ch_r == '0) begin
      used_h = SIZE_W'(1);
    end else if (SIZE_W'(ch_r) > MAXH_S) begin
      used_h = MAXH_S;
    end else begin
      used_h = SIZE_W'(ch_r);
    end
  end

  // sequencer state
  state_t            state_r, state_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [AW-1:0]     row_base_r, row_base_nxt;
  logic [SIZE_W-1:0] lim_w_r, lim_w_nxt, lim_h_r, lim_h_nxt;
  logic [CHAR_W-1:0] wdata_r, wdata_nxt;
  logic              clear_mode_r, clear_mode_nxt;
  logic              fill_r, fill_nxt;
  sts_t              sts_r, sts_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              rend_r, rend_nxt;
  logic [7:0]        col_r, col_nxt, row_r, row_nxt;

  logic              out_valid_r, out_valid_nxt;
  sts_t              out_sts_r, out_sts_nxt;
  logic [CHAR_W-1:0] out_pix_r, out_pix_nxt;
  logic              out_rend_r, out_rend_nxt;

  logic              in_xfer, bnd_start, bnd_done, walking, last_x, last_y;
  logic              paint_hit, mem_we, mem_re;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] rdata;
  bnd_t              bnd;
  logic signed [BND_W-1:0] xs, ys;
  logic              in_x, in_y, on_edge;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign walking   = (state_r == ST_WALK) || (state_r == ST_INIT);
  assign last_x    = (SIZE_W'(x_r) + SIZE_W'(1)) == lim_w_r;
  assign last_y    = (SIZE_W'(y_r) + SIZE_W'(1)) == lim_h_r;

  rrc_bound_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bound (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (bnd_start),
    .rect_left   (in_left),
    .rect_top    (in_top),
    .rect_width  (in_wid),
    .rect_height (in_hgt),
    .bnd         (bnd),
    .done        (bnd_done)
  );

  // pixel test against the integer bounds
  always_comb begin
    xs        = $signed({{(BND_W-XW){1'b0}}, x_r});
    ys        = $signed({{(BND_W-YW){1'b0}}, y_r});
    in_x      = (xs >= bnd.xlo) && (xs <= bnd.xhi);
    in_y      = (ys >= bnd.ylo) && (ys <= bnd.yhi);
    on_edge   = (xs == bnd.xlo) || (xs == bnd.xhi) || (ys == bnd.ylo) || (ys == bnd.yhi);
    paint_hit = in_x && in_y && (fill_r || on_edge);
  end

  assign mem_we = walking && (clear_mode_r || paint_hit);
  assign waddr  = row_base_r + AW'(x_r);
  assign mem_re = (state_r == ST_READ);
  assign raddr  = AW'((32'(row_r) * MAX_WIDTH) + 32'(col_r));

  rrc_canvas_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata_r),
    .re    (mem_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    row_base_nxt   = row_base_r;
    lim_w_nxt      = lim_w_r;
    lim_h_nxt      = lim_h_r;
    wdata_nxt      = wdata_r;
    clear_mode_nxt = clear_mode_r;
    fill_nxt       = fill_r;
    sts_nxt        = sts_r;
    rd_ok_nxt      = rd_ok_r;
    rend_nxt       = rend_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sts_nxt    = out_sts_r;
    out_pix_nxt    = out_pix_r;
    out_rend_nxt   = out_rend_r;
    bnd_start      = 1'b0;

    case (state_r)
      ST_INIT, ST_WALK: begin
        if (last_x) begin
          x_nxt = '0;
          if (last_y) begin
            y_nxt        = '0;
            row_base_nxt = '0;
            state_nxt    = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
          end else begin
            y_nxt        = y_r + YW'(1);
            row_base_nxt = row_base_r + ROW_STEP;
          end
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt        = '0;
          y_nxt        = '0;
          row_base_nxt = '0;
          lim_w_nxt    = used_w;
          lim_h_nxt    = used_h;
          sts_nxt      = STS_OK;
          rd_ok_nxt    = 1'b0;
          rend_nxt     = 1'b0;
          col_nxt      = in_col;
          row_nxt      = in_row;
          fill_nxt     = in_filled;
          case (in_cmd)
            CMD_CLEAR: begin
              wdata_nxt      = bg_r;
              clear_mode_nxt = 1'b1;
              state_nxt      = ST_WALK;
            end
            CMD_DRAW: begin
              wdata_nxt      = in_paint;
              clear_mode_nxt = 1'b0;
              if (in_wid[DATA_W-1] || (in_wid == '0) ||
                  in_hgt[DATA_W-1] || (in_hgt == '0)) begin
                sts_nxt   = STS_REJECT;
                state_nxt = ST_DONE;
              end else begin
                bnd_start = 1'b1;
                state_nxt = ST_SETUP;
              end
            end
            CMD_READ: begin
              if ((SIZE_W'(in_col) >= used_w) || (SIZE_W'(in_row) >= used_h)) begin
                sts_nxt   = STS_RANGE;
                state_nxt = ST_DONE;
              end else begin
                rd_ok_nxt = 1'b1;
                rend_nxt  = (SIZE_W'(in_col) + SIZE_W'(1)) == used_w;
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (bnd_done) begin
          state_nxt = ST_WALK;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = sts_r;
          out_pix_nxt   = rd_ok_r ? rdata : '0;
          out_rend_nxt  = rend_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      x_r          <= '0;
      y_r          <= '0;
      row_base_r   <= '0;
      lim_w_r      <= MAXW_S;
      lim_h_r      <= MAXH_S;
      wdata_r      <= RESET_CHAR;
      clear_mode_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      x_r          <= x_nxt;
      y_r          <= y_nxt;
      row_base_r   <= row_base_nxt;
      lim_w_r      <= lim_w_nxt;
      lim_h_r      <= lim_h_nxt;
      wdata_r      <= wdata_nxt;
      clear_mode_r <= clear_mode_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    sts_r      <= sts_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rend_r     <= rend_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    out_sts_r  <= out_sts_nxt;
    out_pix_r  <= out_pix_nxt;
    out_rend_r <= out_rend_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_pix_r, out_sts_r};
  assign out_tlast  = out_rend_r;

  `RRC_ASSERT_NEXT(a_busy_after_xfer, in_xfer, state_r != ST_IDLE,
    "input transfer did not start work")
  `RRC_ASSERT_NOW(a_walk_x_range, walking, SIZE_W'(x_r) < lim_w_r,
    "walk column beyond limit")
  `RRC_ASSERT_NOW(a_row_base, walking, row_base_r == AW'(32'(y_r) * MAX_WIDTH),
    "row base out of step with row counter")
  `RRC_ASSERT_NOW(a_out_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE,
    "result raised outside the done state")

endmodule
